/* rtl/gpio_pkg.sv */
// Shared types and constants for the GPIO bank with interrupt detection.
// Used by gpio_bank_with_irq_detect_core; depends on nothing else.
`default_nettype none

package gpio_pkg;

	typedef enum logic [1:0] {
		ACT_TICK  = 2'd0,
		ACT_WRITE = 2'd1,
		ACT_READ  = 2'd2,
		ACT_NONE  = 2'd3
	} action_t;

	typedef enum logic [3:0] {
		REG_DIR     = 4'd0,
		REG_DATAIN  = 4'd1,
		REG_DATAOUT = 4'd2,
		REG_SETOUT  = 4'd3,
		REG_CLROUT  = 4'd4,
		REG_STAT0   = 4'd5,
		REG_STAT1   = 4'd6,
		REG_ENSET   = 4'd7,
		REG_ENCLR   = 4'd8,
		REG_LVL0    = 4'd9,
		REG_LVL1    = 4'd10,
		REG_RISE    = 4'd11,
		REG_FALL    = 4'd12,
		REG_CTRL    = 4'd13,
		REG_RSVD14  = 4'd14,
		REG_RSVD15  = 4'd15
	} reg_index_t;

	localparam int unsigned DataWidth  = 32;
	localparam int unsigned InTdataW   = 64;
	localparam int unsigned InTuserW   = 6;
	localparam int unsigned OutTdataW  = 104;

	// Control bit 0 set means event detection is disabled.
	localparam int unsigned CtrlDisableBit = 0;

	typedef struct packed {
		logic [DataWidth-1:0] pins_in;
		logic [DataWidth-1:0] write_data;
		reg_index_t           reg_index;
		action_t              action;
	} request_t;

endpackage

`default_nettype wire

/* rtl/gpio_bank_with_irq_detect_core.sv */
// GPIO bank with per-pin level and edge interrupt detection: a register file of
// direction, data out, detect masks, status and enable, and the interrupt line.
// One request enters each cycle; every request gives one response through the
// input register, then the output register. Throughput is one request per
// cycle, limited only by downstream tready. Responses carry the register state
// after the request, plus read data for register reads. Depends on gpio_pkg.
`default_nettype none

module gpio_bank_with_irq_detect_core #(
	parameter int unsigned PIN_COUNT = 32
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             s_tvalid,
	output logic                                  s_tready,
	// tdata: write_data [31:0], pins_in [63:32]
	input  wire logic [gpio_pkg::InTdataW-1:0]    s_tdata,
	// tuser: action [1:0], reg_index [5:2]
	input  wire logic [gpio_pkg::InTuserW-1:0]    s_tuser,
	output logic                                  m_tvalid,
	input  wire logic                             m_tready,
	// tdata: read_data [31:0], pins_drive [63:32], pins_output_enable [95:64],
	// irq_out [96], zero padding [103:97]
	output logic [gpio_pkg::OutTdataW-1:0]        m_tdata
);

	localparam int unsigned DW = gpio_pkg::DataWidth;
	localparam logic [DW:0] PinMaskWide = (33'd1 << PIN_COUNT) - 33'd1;
	localparam logic [DW-1:0] PinMask = PinMaskWide[DW-1:0];

	gpio_pkg::request_t req_s1;
	logic               valid_s1;
	logic               advance;

	logic [DW-1:0] dir_q, dout_q, lvl0_q, lvl1_q, rise_q, fall_q;
	logic [DW-1:0] stat_q, en_q, ctrl_q, prev_q;
	logic [DW-1:0] dir_d, dout_d, lvl0_d, lvl1_d, rise_d, fall_d;
	logic [DW-1:0] stat_d, en_d, ctrl_d, prev_d;
	logic [DW-1:0] rdata_d, pins, wmask, events;

	logic          out_valid_q;
	logic [DW-1:0] rdata_q, drive_q, oe_q;
	logic          irq_q;

	assign advance  = !out_valid_q || m_tready;
	assign s_tready = !valid_s1 || advance;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			req_s1.write_data <= s_tdata[DW-1:0];
			req_s1.pins_in    <= s_tdata[2*DW-1:DW];
			req_s1.action     <= gpio_pkg::action_t'(s_tuser[1:0]);
			req_s1.reg_index  <= gpio_pkg::reg_index_t'(s_tuser[5:2]);
		end
	end

	// Next register state and read data for the request in the input register.
	always_comb begin
		pins   = req_s1.pins_in & PinMask;
		wmask  = req_s1.write_data & PinMask;
		events = (~pins & lvl0_q) | (pins & lvl1_q) | (pins & ~prev_q & rise_q)
			| (~pins & prev_q & fall_q);
		dir_d   = dir_q;
		dout_d  = dout_q;
		lvl0_d  = lvl0_q;
		lvl1_d  = lvl1_q;
		rise_d  = rise_q;
		fall_d  = fall_q;
		stat_d  = stat_q;
		en_d    = en_q;
		ctrl_d  = ctrl_q;
		prev_d  = prev_q;
		rdata_d = '0;
		unique case (req_s1.action)
			gpio_pkg::ACT_TICK: begin
				if (!ctrl_q[gpio_pkg::CtrlDisableBit]) begin
					stat_d = stat_q | (events & PinMask);
				end
				prev_d = pins;
			end
			gpio_pkg::ACT_WRITE: begin
				unique case (req_s1.reg_index)
					gpio_pkg::REG_DIR:     dir_d  = wmask;
					gpio_pkg::REG_DATAOUT: dout_d = wmask;
					gpio_pkg::REG_SETOUT:  dout_d = dout_q | wmask;
					gpio_pkg::REG_CLROUT:  dout_d = dout_q & ~wmask;
					gpio_pkg::REG_STAT0,
					gpio_pkg::REG_STAT1:   stat_d = stat_q & ~wmask;
					gpio_pkg::REG_ENSET:   en_d   = en_q | wmask;
					gpio_pkg::REG_ENCLR:   en_d   = en_q & ~wmask;
					gpio_pkg::REG_LVL0:    lvl0_d = wmask;
					gpio_pkg::REG_LVL1:    lvl1_d = wmask;
					gpio_pkg::REG_RISE:    rise_d = wmask;
					gpio_pkg::REG_FALL:    fall_d = wmask;
					gpio_pkg::REG_CTRL:    ctrl_d = req_s1.write_data;
					default: ;
				endcase
			end
			gpio_pkg::ACT_READ: begin
				unique case (req_s1.reg_index)
					gpio_pkg::REG_DIR:     rdata_d = dir_q;
					gpio_pkg::REG_DATAIN:  rdata_d = prev_q;
					gpio_pkg::REG_DATAOUT,
					gpio_pkg::REG_SETOUT,
					gpio_pkg::REG_CLROUT:  rdata_d = dout_q;
					gpio_pkg::REG_STAT0,
					gpio_pkg::REG_STAT1:   rdata_d = stat_q;
					gpio_pkg::REG_ENSET,
					gpio_pkg::REG_ENCLR:   rdata_d = en_q;
					gpio_pkg::REG_LVL0:    rdata_d = lvl0_q;
					gpio_pkg::REG_LVL1:    rdata_d = lvl1_q;
					gpio_pkg::REG_RISE:    rdata_d = rise_q;
					gpio_pkg::REG_FALL:    rdata_d = fall_q;
					gpio_pkg::REG_CTRL:    rdata_d = ctrl_q;
					default:               rdata_d = '0;
				endcase
			end
			default: ;
		endcase
	end

	// Register state commits when the request moves into the output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dir_q  <= PinMask;
			dout_q <= '0;
			lvl0_q <= '0;
			lvl1_q <= '0;
			rise_q <= '0;
			fall_q <= '0;
			stat_q <= '0;
			en_q   <= '0;
			ctrl_q <= '0;
			prev_q <= '0;
		end else if (valid_s1 && advance) begin
			dir_q  <= dir_d;
			dout_q <= dout_d;
			lvl0_q <= lvl0_d;
			lvl1_q <= lvl1_d;
			rise_q <= rise_d;
			fall_q <= fall_d;
			stat_q <= stat_d;
			en_q   <= en_d;
			ctrl_q <= ctrl_d;
			prev_q <= prev_d;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && advance) begin
			rdata_q <= rdata_d;
			drive_q <= dout_d & PinMask;
			oe_q    <= ~dir_d & PinMask;
			irq_q   <= |(stat_d & en_d);
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {7'd0, irq_q, oe_q, drive_q, rdata_q};

endmodule

`default_nettype wire

/* tb/tb_gpio_bank_with_irq_detect_core.sv */
`timescale 1ns / 1ps
// Self-checking testbench for gpio_bank_with_irq_detect_core: directed and random register
// traffic and pin ticks, every response compared with a behavioral register model.
// Depends on gpio_pkg and the core RTL.

module tb_gpio_bank_with_irq_detect_core;

	localparam int unsigned DW = gpio_pkg::DataWidth;
	localparam int unsigned CycleLimit = 200000;
	localparam int unsigned RandomRequests = 1000;
	localparam int unsigned DrainCycles = 10;

	typedef struct packed {
		logic          irq;
		logic [DW-1:0] oe;
		logic [DW-1:0] drive;
		logic [DW-1:0] rdata;
	} response_t;

	// Register model of the bank plus the queue of responses it predicts.
	class gpio_scoreboard;
		logic [DW-1:0] dir_mask, out_word, low_detect, high_detect;
		logic [DW-1:0] rise_detect, fall_detect, status, enable, ctrl_word, sampled_pins;
		response_t responses_due[$];
		int unsigned errors;

		function new();
			dir_mask = '1;
			out_word = '0;
			low_detect = '0;
			high_detect = '0;
			rise_detect = '0;
			fall_detect = '0;
			status = '0;
			enable = '0;
			ctrl_word = '0;
			sampled_pins = '0;
			errors = 0;
		endfunction

		function int unsigned pending();
			return responses_due.size();
		endfunction

		function logic [DW-1:0] read_register(gpio_pkg::reg_index_t idx);
			case (idx)
			gpio_pkg::REG_DIR: return dir_mask;
			gpio_pkg::REG_DATAIN: return sampled_pins;
			gpio_pkg::REG_DATAOUT,
			gpio_pkg::REG_SETOUT,
			gpio_pkg::REG_CLROUT: return out_word;
			gpio_pkg::REG_STAT0, gpio_pkg::REG_STAT1: return status;
			gpio_pkg::REG_ENSET, gpio_pkg::REG_ENCLR: return enable;
			gpio_pkg::REG_LVL0: return low_detect;
			gpio_pkg::REG_LVL1: return high_detect;
			gpio_pkg::REG_RISE: return rise_detect;
			gpio_pkg::REG_FALL: return fall_detect;
			gpio_pkg::REG_CTRL: return ctrl_word;
			default: return '0;
			endcase
		endfunction

		function void note_request(gpio_pkg::action_t act, gpio_pkg::reg_index_t idx,
				logic [DW-1:0] wdata, logic [DW-1:0] pins);
			logic [DW-1:0] events;
			response_t due;
			due = '0;
			case (act)
			gpio_pkg::ACT_TICK: begin
				// A disabled bank still remembers the sample for later edge detection.
				if (!ctrl_word[gpio_pkg::CtrlDisableBit]) begin
					events = (~pins & low_detect) | (pins & high_detect)
						| (pins & ~sampled_pins & rise_detect)
						| (~pins & sampled_pins & fall_detect);
					status |= events;
				end
				sampled_pins = pins;
			end
			gpio_pkg::ACT_WRITE: begin
				case (idx)
				gpio_pkg::REG_DIR: dir_mask = wdata;
				gpio_pkg::REG_DATAOUT: out_word = wdata;
				gpio_pkg::REG_SETOUT: out_word |= wdata;
				gpio_pkg::REG_CLROUT: out_word &= ~wdata;
				gpio_pkg::REG_STAT0, gpio_pkg::REG_STAT1: status &= ~wdata;
				gpio_pkg::REG_ENSET: enable |= wdata;
				gpio_pkg::REG_ENCLR: enable &= ~wdata;
				gpio_pkg::REG_LVL0: low_detect = wdata;
				gpio_pkg::REG_LVL1: high_detect = wdata;
				gpio_pkg::REG_RISE: rise_detect = wdata;
				gpio_pkg::REG_FALL: fall_detect = wdata;
				gpio_pkg::REG_CTRL: ctrl_word = wdata;
				default: ;
				endcase
			end
			gpio_pkg::ACT_READ: due.rdata = read_register(idx);
			default: ;
			endcase
			due.drive = out_word;
			due.oe = ~dir_mask;
			due.irq = |(status & enable);
			responses_due.push_back(due);
		endfunction

		task report(string field, logic [DW-1:0] got, logic [DW-1:0] want);
			$display("MISMATCH %s: got %h, want %h", field, got, want);
			errors++;
		endtask

		task check_response(logic [gpio_pkg::OutTdataW-1:0] tdata);
			response_t due;
			if (responses_due.size() == 0) begin
				report("response with none pending", tdata[31:0], '0);
				return;
			end
			due = responses_due.pop_front();
			if (tdata[31:0] !== due.rdata)
				report("read_data", tdata[31:0], due.rdata);
			if (tdata[63:32] !== due.drive)
				report("pins_drive", tdata[63:32], due.drive);
			if (tdata[95:64] !== due.oe)
				report("pins_output_enable", tdata[95:64], due.oe);
			if (tdata[96] !== due.irq)
				report("irq_out", {31'b0, tdata[96]}, {31'b0, due.irq});
		endtask
	endclass

	logic                                clk;
	logic                                arst_n = 1'b0;
	logic                                s_tvalid = 1'b0;
	logic                                s_tready;
	logic [gpio_pkg::InTdataW-1:0]       s_tdata = '0;
	logic [gpio_pkg::InTuserW-1:0]       s_tuser = '0;
	logic                                m_tvalid;
	logic                                m_tready = 1'b0;
	logic [gpio_pkg::OutTdataW-1:0]      m_tdata;

	gpio_scoreboard sb;
	bit             calm = 1'b0;
	int unsigned    cycles = 0;
	logic [DW-1:0]  last_pins = '0;

	gpio_bank_with_irq_detect_core uut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Response side: random back-pressure, checking and the overall cycle limit.
	always @(posedge clk) begin
		cycles++;
		if (cycles == CycleLimit) begin
			$display("DONE: errors detected");
			$finish;
		end else begin
			if (arst_n && m_tvalid && m_tready)
				sb.check_response(m_tdata);
			m_tready <= calm || ($urandom_range(99) >= 13);
		end
	end

	task automatic send_request(input gpio_pkg::action_t act, input gpio_pkg::reg_index_t idx,
			input logic [DW-1:0] wdata, input logic [DW-1:0] pins);
		while (!calm && $urandom_range(99) < 13) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {pins, wdata};
		s_tuser <= {idx, act};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		sb.note_request(act, idx, wdata, pins);
		if (act == gpio_pkg::ACT_TICK)
			last_pins = pins;
	endtask

	// Sparse masks keep the detect and status registers from saturating.
	function automatic logic [DW-1:0] pick_word();
		case ($urandom_range(0, 7))
		0: return '0;
		1: return '1;
		2: return 32'h1 << $urandom_range(0, 31);
		3: return ~(32'h1 << $urandom_range(0, 31));
		4: return $urandom() & $urandom() & $urandom();
		default: return $urandom();
		endcase
	endfunction

	function automatic logic [DW-1:0] pick_pins();
		case ($urandom_range(0, 5))
		0: return '0;
		1: return '1;
		2: return $urandom();
		default: return last_pins ^ (32'h1 << $urandom_range(0, 31));
		endcase
	endfunction

	initial begin
		int unsigned useful;
		int unsigned roll;
		bit paused;
		gpio_pkg::action_t act;
		gpio_pkg::reg_index_t idx;
		sb = new();
		useful = 0;
		paused = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_request(gpio_pkg::ACT_READ, gpio_pkg::REG_DIR, 32'h0, 32'h0);
		send_request(gpio_pkg::ACT_WRITE, gpio_pkg::REG_DIR, 32'h0, 32'hFFFF_FFFF);
		send_request(gpio_pkg::ACT_WRITE, gpio_pkg::REG_DATAOUT, 32'hFFFF_FFFF, 32'h0);
		send_request(gpio_pkg::ACT_WRITE, gpio_pkg::REG_CLROUT, 32'h0000_FFFF, 32'h0);
		send_request(gpio_pkg::ACT_WRITE, gpio_pkg::REG_SETOUT, 32'h0000_0001, 32'h0);
		send_request(gpio_pkg::ACT_READ, gpio_pkg::REG_SETOUT, 32'h0, 32'h0);
		send_request(gpio_pkg::ACT_READ, gpio_pkg::REG_CLROUT, 32'h0, 32'h0);
		// Read-only and reserved registers must not change anything.
		send_request(gpio_pkg::ACT_WRITE, gpio_pkg::REG_DATAIN, 32'hFFFF_FFFF, 32'h0);
		send_request(gpio_pkg::ACT_READ, gpio_pkg::REG_DATAIN, 32'h0, 32'h0);
		send_request(gpio_pkg::ACT_WRITE, gpio_pkg::REG_RSVD14, 32'hFFFF_FFFF, 32'h0);
		send_request(gpio_pkg::ACT_READ, gpio_pkg::REG_RSVD15, 32'h0, 32'h0);
		send_request(gpio_pkg::ACT_NONE, gpio_pkg::REG_RSVD15, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_request(gpio_pkg::ACT_WRITE, gpio_pkg::REG_ENSET, 32'hFFFF_FFFF, 32'h0);
		send_request(gpio_pkg::ACT_WRITE, gpio_pkg::REG_LVL1, 32'h8000_0000, 32'h0);
		send_request(gpio_pkg::ACT_TICK, gpio_pkg::REG_DIR, 32'h0, 32'hFFFF_FFFF);
		send_request(gpio_pkg::ACT_READ, gpio_pkg::REG_STAT0, 32'h0, 32'h0);
		send_request(gpio_pkg::ACT_WRITE, gpio_pkg::REG_STAT1, 32'hFFFF_FFFF, 32'h0);
		send_request(gpio_pkg::ACT_WRITE, gpio_pkg::REG_RISE, 32'h0000_00FF, 32'h0);
		send_request(gpio_pkg::ACT_WRITE, gpio_pkg::REG_FALL, 32'h0000_FF00, 32'h0);
		send_request(gpio_pkg::ACT_TICK, gpio_pkg::REG_DIR, 32'h0, 32'h0000_00FF);
		send_request(gpio_pkg::ACT_WRITE, gpio_pkg::REG_LVL0, 32'h0000_0001, 32'h0);
		send_request(gpio_pkg::ACT_WRITE, gpio_pkg::REG_CTRL, 32'hFFFF_FFFE, 32'h0);
		send_request(gpio_pkg::ACT_TICK, gpio_pkg::REG_DIR, 32'h0, 32'h0);
		// With detection disabled the sample is still taken for the data-in register.
		send_request(gpio_pkg::ACT_WRITE, gpio_pkg::REG_CTRL, 32'hFFFF_FFFF, 32'h0);
		send_request(gpio_pkg::ACT_TICK, gpio_pkg::REG_DIR, 32'h0, 32'hFFFF_FFFF);
		send_request(gpio_pkg::ACT_READ, gpio_pkg::REG_DATAIN, 32'h0, 32'h0);
		send_request(gpio_pkg::ACT_WRITE, gpio_pkg::REG_ENCLR, 32'hFFFF_FFFF, 32'h0);
		send_request(gpio_pkg::ACT_READ, gpio_pkg::REG_STAT1, 32'h0, 32'h0);
		send_request(gpio_pkg::ACT_WRITE, gpio_pkg::REG_CTRL, 32'h0, 32'h0);

		while (useful < RandomRequests) begin
			calm = (useful >= 300 && useful < 450);
			if (useful == 600 && !paused) begin
				paused = 1'b1;
				if (sb.pending() != 0) begin
					s_tvalid <= 1'b0;
					while (sb.pending() != 0)
						@(posedge clk);
				end
			end
			roll = $urandom_range(0, 99);
			if (roll < 40)
				act = gpio_pkg::ACT_TICK;
			else if (roll < 72)
				act = gpio_pkg::ACT_WRITE;
			else if (roll < 96)
				act = gpio_pkg::ACT_READ;
			else
				act = gpio_pkg::ACT_NONE;
			idx = gpio_pkg::reg_index_t'($urandom_range(0, 15));
			send_request(act, idx, pick_word(), pick_pins());
			if (!(act == gpio_pkg::ACT_NONE
					|| (act == gpio_pkg::ACT_WRITE
					&& (idx == gpio_pkg::REG_DATAIN || idx >= gpio_pkg::REG_RSVD14))))
				useful++;
		end
		calm = 1'b0;

		s_tvalid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (DrainCycles) @(posedge clk);
		if (sb.errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

/* files.f */
rtl/gpio_pkg.sv
rtl/gpio_bank_with_irq_detect_core.sv
tb/tb_gpio_bank_with_irq_detect_core.sv
